// ===== sv/sha224_stream_hash_unit_assert.svh =====
// assertion macros for the sha224 stream hash unit
`ifndef SHA224_STREAM_HASH_UNIT_ASSERT_SVH
`define SHA224_STREAM_HASH_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sha224_pkg.sv =====
// ----------------------------------------------------------------------------
// sha224_pkg
// types, constants and the rotate function shared by the sha224 stream hash unit
// ----------------------------------------------------------------------------
package sha224_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// control from sequencer to round unit
	typedef struct packed {
		logic       init;
		logic       step;
		logic       fold;
		logic [5:0] round;
	} rnd_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== sv/sha224_round.sv =====
// ----------------------------------------------------------------------------
// sha224_round
// one sha-256 round per cycle on ctl.step, rolling 16-word message schedule
// ----------------------------------------------------------------------------
module sha224_round (
	input  logic                clk,
	input  logic                arst_n,
	input  sha224_pkg::rnd_ctl_t ctl,
	input  logic [31:0]         blk [16],
	output logic [31:0]         chain [8]
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] chain_q [8];
	logic [31:0] s0, s1, w_new, big_s1, ch, t1, big_s0, maj, t2;

	always_comb begin
		s0     = sha224_pkg::rotr(w_q[1], 7) ^ sha224_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1     = sha224_pkg::rotr(w_q[14], 17) ^ sha224_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		w_new  = w_q[0] + s0 + w_q[9] + s1;
		big_s1 = sha224_pkg::rotr(v_q[4], 6) ^ sha224_pkg::rotr(v_q[4], 11)
			^ sha224_pkg::rotr(v_q[4], 25);
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1     = v_q[7] + big_s1 + ch + sha224_pkg::ROUND_K[ctl.round] + w_q[0];
		big_s0 = sha224_pkg::rotr(v_q[0], 2) ^ sha224_pkg::rotr(v_q[0], 13)
			^ sha224_pkg::rotr(v_q[0], 22);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2     = big_s0 + maj;
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			w_q <= blk;
			v_q <= chain_q;
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			for (int i = 1; i < 8; i++) v_q[i] <= v_q[i-1];
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha224_pkg::INIT_HASH;
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
		end else if (ctl.init && ctl.round == 6'd63) begin
			// init with round 63 marks the return to initial values
			chain_q <= sha224_pkg::INIT_HASH;
		end
	end

	assign chain = chain_q;

endmodule

// ===== sv/sha224_stream_hash_unit.sv =====
// a byte that fills no block is simply taken in idle; a block fill adds a load,
// 64 rounds at one per cycle and a fold; end of message adds one or two blocks
// and then 7 digest transactions, one per cycle while out_ready is high
// bytes are taken only in idle and stall while the single round unit works a block
// reset: asynchronous active low, chaining words return to the initial values
// ----------------------------------------------------------------------------
// sha224_stream_hash_unit
// byte-serial sha-224 with padding, length append and digest output
// ----------------------------------------------------------------------------
`include "sha224_stream_hash_unit_assert.svh"

module sha224_stream_hash_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha224_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha224_pkg::out_item_t out_data
);

	sha224_pkg::state_t state_q, state_d;
	logic [63:0] count_q;
	logic [31:0] blk_q [16];
	logic [31:0] chain [8];
	logic [5:0]  round_q;
	logic        fin_q;       // message is being finished
	logic        pad_len_q;   // next compress carries the length block
	logic        pad_room_q;  // length words fit behind the pad byte
	logic [2:0]  idx_q;
	sha224_pkg::rnd_ctl_t ctl;
	logic        acc;
	logic [5:0]  pos;
	logic [5:0]  pad_pos;
	logic        blk_full;
	logic [63:0] bits;

	assign acc      = in_valid && in_ready;
	assign in_ready = (state_q == sha224_pkg::ST_IDLE);
	assign pos      = count_q[5:0];
	assign pad_pos  = in_data.byte_present ? pos + 6'd1 : pos;
	assign blk_full = in_data.byte_present && pos == 6'd63;
	assign bits     = {count_q[60:0], 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sha224_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		ctl.round  = round_q;
		case (state_q)
			sha224_pkg::ST_IDLE: begin
				if (acc) begin
					if (blk_full) begin
						state_d = sha224_pkg::ST_LOAD;
					end else if (in_data.end_of_message) begin
						state_d = sha224_pkg::ST_PAD;
					end
				end
			end
			sha224_pkg::ST_PAD: begin
				state_d = sha224_pkg::ST_LOAD;
			end
			sha224_pkg::ST_LOAD: begin
				state_d   = sha224_pkg::ST_ROUND;
				ctl.init  = 1'b1;
				ctl.round = 6'd0;
			end
			sha224_pkg::ST_ROUND: begin
				ctl.step = 1'b1;
				if (round_q == 6'd63) state_d = sha224_pkg::ST_FOLD;
			end
			sha224_pkg::ST_FOLD: begin
				ctl.fold = 1'b1;
				if (!fin_q)          state_d = sha224_pkg::ST_IDLE;
				else if (pad_len_q)  state_d = sha224_pkg::ST_EMIT;
				else                 state_d = sha224_pkg::ST_PAD;
			end
			sha224_pkg::ST_EMIT: begin
				if (out_ready && idx_q == 3'd6) begin
					state_d   = sha224_pkg::ST_IDLE;
					ctl.init  = 1'b1;
					ctl.round = 6'd63;
				end
			end
			default: state_d = sha224_pkg::ST_IDLE;
		endcase
	end

	sha224_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk_q),
		.chain  (chain)
	);

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			round_q   <= '0;
			fin_q     <= 1'b0;
			pad_len_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (state_q == sha224_pkg::ST_ROUND) round_q <= round_q + 6'd1;
			case (state_q)
				sha224_pkg::ST_IDLE: begin
					if (acc) begin
						if (in_data.byte_present) count_q <= count_q + 64'd1;
						fin_q <= in_data.end_of_message;
					end
				end
				sha224_pkg::ST_PAD: begin
					// pad decision and length insertion happen in the block path
				end
				sha224_pkg::ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd6) begin
							idx_q     <= '0;
							count_q   <= '0;
							fin_q     <= 1'b0;
							pad_len_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
			if (state_q == sha224_pkg::ST_PAD) pad_len_q <= pad_room_q;
		end
	end

	// the pad stage loads the length block exactly when the padded data left room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_room_q <= 1'b1;
		end else begin
			if (state_q == sha224_pkg::ST_IDLE && acc && in_data.end_of_message) begin
				pad_room_q <= blk_full ? 1'b1 : (pad_pos < 6'd56);
			end
			if (state_q == sha224_pkg::ST_FOLD && fin_q && !pad_len_q && !pad_room_q) begin
				pad_room_q <= 1'b1;
			end
		end
	end

	// block buffer
	always_ff @(posedge clk) begin
		if (state_q == sha224_pkg::ST_IDLE && acc) begin
			if (in_data.byte_present) begin
				blk_q[pos[5:2]][(5'd24 - {pos[1:0], 3'b000}) +: 8] <= in_data.data_byte;
			end
			if (in_data.end_of_message && !blk_full) begin
				for (int i = 0; i < 64; i++) begin
					if (6'(i) > pad_pos) blk_q[i/4][24 - 8*(i%4) +: 8] <= 8'h00;
				end
				blk_q[pad_pos[5:2]][(5'd24 - {pad_pos[1:0], 3'b000}) +: 8] <=
					sha224_pkg::PAD_BYTE;
			end
		end
		if (state_q == sha224_pkg::ST_FOLD && fin_q && !pad_len_q) begin
			// overflow block: pad byte leads when the data ended on a block edge
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
			if (pad_room_q) begin
				blk_q[0] <= {sha224_pkg::PAD_BYTE, 24'h0};
			end
		end
		if (state_q == sha224_pkg::ST_PAD && pad_room_q) begin
			blk_q[14] <= bits[63:32];
			blk_q[15] <= bits[31:0];
		end
	end

	assign out_valid            = (state_q == sha224_pkg::ST_EMIT);
	assign out_data.digest_word = chain[idx_q];
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = (idx_q == 3'd6);

	`SHA_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid, "ready while emitting")
	`SHA_ASSERT_IMP(a_idx_range, clk, arst_n, out_valid, idx_q <= 3'd6, "digest index range")
	`SHA_ASSERT_NEXT(a_last_done, clk, arst_n, out_valid && out_ready && out_data.last_word,
		in_ready, "not idle after last word")

endmodule
